### rtl/scf_pkg.sv
package scf_pkg;

  localparam int MAX_DATA = 32;
  localparam int CNT_W    = $clog2(MAX_DATA + 1);
  localparam int ADDR_W   = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] CK_MASK   = 8'hFE;
  localparam logic [7:0] HDR_BYTES = 8'd7;

  // Position of each header byte within the frame.
  localparam logic [2:0] HDR_SYNC0 = 3'd0;
  localparam logic [2:0] HDR_SYNC1 = 3'd1;
  localparam logic [2:0] HDR_SIZE  = 3'd2;
  localparam logic [2:0] HDR_ID    = 3'd3;
  localparam logic [2:0] HDR_CMD   = 3'd4;
  localparam logic [2:0] HDR_CK1   = 3'd5;
  localparam logic [2:0] HDR_CK2   = 3'd6;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       xsum;
    logic             ovf;
  } scf_stat_t;

endpackage

### rtl/scf_ram.sv
module scf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/scf_accum.sv
module scf_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               payload_byte,
  input  logic                     has_payload,
  input  logic                     clear,
  output logic                     wr_en,
  output logic [scf_pkg::ADDR_W-1:0] wr_addr,
  output logic [7:0]               wr_data,
  output scf_pkg::scf_stat_t       stat
);
  import scf_pkg::*;

  logic [CNT_W-1:0] count;
  logic [7:0]       xsum;
  logic             ovf;
  logic             room;

  assign room    = (count < CNT_W'(MAX_DATA));
  assign wr_en   = accept && has_payload && room;
  assign wr_addr = count[ADDR_W-1:0];
  assign wr_data = payload_byte;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      xsum  <= '0;
      ovf   <= 1'b0;
    end else if (accept && has_payload) begin
      if (room) begin
        count <= count + CNT_W'(1);
        xsum  <= xsum ^ payload_byte;
      end else begin
        // A full buffer drops the byte and flags the overflow for the frame.
        ovf <= 1'b1;
      end
    end
  end

  assign stat.count = count;
  assign stat.xsum  = xsum;
  assign stat.ovf   = ovf;

endmodule

### rtl/scf_emit.sv
module scf_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [7:0]               target_addr,
  input  logic [7:0]               command,
  input  scf_pkg::scf_stat_t       stat,
  output logic                     rd_en,
  output logic [scf_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]               rd_data,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [7:0]               frame_byte,
  output logic                     frame_last,
  output logic                     overflow,
  output logic                     busy,
  output logic                     clear
);
  import scf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_RADDR = 2'd2;
  localparam logic [1:0] S_RDATA = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [2:0]       hidx;
  logic [CNT_W-1:0] pidx;
  logic [7:0]       id_q;
  logic [7:0]       cmd_q;
  logic [7:0]       acc;
  logic [7:0]       size;
  logic [7:0]       alu_a;
  logic [7:0]       alu_b;
  logic [7:0]       alu_y;
  logic             slot_free;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic             pay_last;

  assign size      = 8'(stat.count) + HDR_BYTES;
  assign slot_free = !out_valid || !out_stall;
  assign pay_last  = (CNT_W'(pidx + CNT_W'(1)) == stat.count);

  // One XOR unit folds size, payload checksum, id and command over the
  // header steps; the checksum bytes then read the folded value.
  always_comb begin
    alu_a = (hidx == HDR_SIZE) ? size : acc;
    case (hidx)
      HDR_SIZE: alu_b = stat.xsum;
      HDR_ID:   alu_b = id_q;
      HDR_CMD:  alu_b = cmd_q;
      default:  alu_b = 8'h00;
    endcase
    alu_y = alu_a ^ alu_b;
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    load_byte  = rd_data;
    load_last  = 1'b0;
    rd_en      = 1'b0;
    clear      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        case (hidx)
          HDR_SYNC0: load_byte = SYNC_BYTE;
          HDR_SYNC1: load_byte = SYNC_BYTE;
          HDR_SIZE:  load_byte = size;
          HDR_ID:    load_byte = id_q;
          HDR_CMD:   load_byte = cmd_q;
          HDR_CK1:   load_byte = acc & CK_MASK;
          HDR_CK2:   load_byte = ~acc & CK_MASK;
          default:   load_byte = 8'h00;
        endcase
        load_last = (hidx == HDR_CK2) && (stat.count == '0);
        if (slot_free) begin
          load = 1'b1;
          if (hidx == HDR_CK2) begin
            if (stat.count == '0) begin
              state_next = S_IDLE;
              clear      = 1'b1;
            end else begin
              state_next = S_RADDR;
            end
          end
        end
      end
      S_RADDR: begin
        rd_en      = 1'b1;
        state_next = S_RDATA;
      end
      S_RDATA: begin
        load_last = pay_last;
        if (slot_free) begin
          load = 1'b1;
          if (pay_last) begin
            state_next = S_IDLE;
            clear      = 1'b1;
          end else begin
            state_next = S_RADDR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_addr = pidx[ADDR_W-1:0];
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      id_q  <= target_addr;
      cmd_q <= command;
      hidx  <= HDR_SYNC0;
      pidx  <= '0;
    end else if (state == S_HDR && slot_free) begin
      acc  <= alu_y;
      hidx <= hidx + 3'd1;
    end else if (state == S_RDATA && slot_free) begin
      pidx <= pidx + CNT_W'(1);
    end
    if (load) begin
      frame_byte <= load_byte;
      frame_last <= load_last;
      overflow   <= stat.ovf;
    end
  end

endmodule

### rtl/servo_command_packet_framer_core.sv
// An accepted end item moves the sequencer to its header state, which then registers
// the first frame byte out when the slot is free. Items not marked last never stall the
// input; the end item stalls it through seven header bytes and, per payload byte, a read
// address and a read data state (one registered read port), more while output stalls.
// Reset clears the sequencer, output valid, byte count, running XOR and overflow flag;
// the payload buffer is not cleared, since only bytes written in a packet are read.
module servo_command_packet_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] target_addr,
  input  logic [7:0] command,
  input  logic [7:0] payload_byte,
  input  logic       has_payload,
  input  logic       end_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_last,
  output logic       overflow
);
  import scf_pkg::*;

  logic              accept;
  logic              busy;
  logic              clear;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  scf_stat_t         stat;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  scf_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .clear        (clear),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .stat         (stat)
  );

  scf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DATA)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  scf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && end_of_packet),
    .target_addr (target_addr),
    .command     (command),
    .stat        (stat),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .overflow    (overflow),
    .busy        (busy),
    .clear       (clear)
  );

endmodule

### rtl/scf_checker.sv
module scf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       end_of_packet,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] frame_byte,
  input logic       frame_last,
  input logic       overflow
);

  // A stalled output item keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(frame_last)
      && $stable(overflow))
    else $error("stalled output item changed");

  // An accepted end item starts a frame, so input is stalled next.
  a_eop_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_packet |=> in_stall)
    else $error("input not stalled after end item");

  // Until the last byte of a frame is loaded, no new item is taken.
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> in_stall)
    else $error("input open in the middle of a frame");

  // Leaving the busy phase coincides with the last frame byte on offer.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) && !$past(rst) |-> out_valid && frame_last)
    else $error("frame ended without its last byte");

endmodule

bind servo_command_packet_framer_core scf_checker u_chk (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import scf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] pb;
    logic       has;
    logic       eop;
    bit         hold;
  } send_item_t;

  typedef struct {
    logic [7:0] fbyte;
    logic       flast;
    logic       fovf;
  } wire_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] target_addr = 8'h00;
  logic [7:0] command = 8'h00;
  logic [7:0] payload_byte = 8'h00;
  logic       has_payload = 1'b0;
  logic       end_of_packet = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic       overflow;

  send_item_t send_items[$];
  wire_byte_t frame_expect[$];
  wire_byte_t want;
  send_item_t nxt;

  // Predictor copy of the packet buffer.
  logic [7:0] held_bytes[MAX_DATA];
  int         held_n = 0;
  logic [7:0] held_xor = 8'h00;
  logic       held_drop = 1'b0;

  int  err_count = 0;
  int  cycle_count = 0;
  bit  in_sent = 1'b0;
  int  send_gap = 0;
  int  send_calm = 0;
  int  recv_wait = 0;
  int  recv_calm = 0;
  logic nxt_valid;

  servo_command_packet_framer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .target_addr(target_addr),
    .command(command),
    .payload_byte(payload_byte),
    .has_payload(has_payload),
    .end_of_packet(end_of_packet),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_byte(frame_byte),
    .frame_last(frame_last),
    .overflow(overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Wait draw with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  task automatic push_frame_byte(input logic [7:0] b, input logic last);
    wire_byte_t wb;
    wb.fbyte = b;
    wb.flast = last;
    wb.fovf = held_drop;
    frame_expect = {frame_expect, wb};
  endtask

  task automatic build_frame(input logic [7:0] id, input logic [7:0] cmd,
                             input logic [7:0] pb, input logic has, input logic eop);
    logic [7:0] hdr[7];
    logic [7:0] sz;
    logic [7:0] ck1;
    int total;
    if (has) begin
      if (held_n < MAX_DATA) begin
        held_bytes[held_n] = pb;
        held_n++;
        held_xor ^= pb;
      end else begin
        held_drop = 1'b1;
      end
    end
    if (eop) begin
      sz = HDR_BYTES + 8'(held_n);
      ck1 = (sz ^ id ^ cmd ^ held_xor) & CK_MASK;
      hdr = '{SYNC_BYTE, SYNC_BYTE, sz, id, cmd, ck1, ~ck1 & CK_MASK};
      total = 7 + held_n;
      for (int k = 0; k < 7; k++) push_frame_byte(hdr[k], k == total - 1);
      for (int k = 0; k < held_n; k++) push_frame_byte(held_bytes[k], 7 + k == total - 1);
      held_n = 0;
      held_xor = 8'h00;
      held_drop = 1'b0;
    end
  endtask

  task automatic add_item(input logic [7:0] id, input logic [7:0] cmd, input logic [7:0] pb,
                          input logic has, input logic eop, input bit hold);
    send_item_t it;
    it.id = id;
    it.cmd = cmd;
    it.pb = pb;
    it.has = has;
    it.eop = eop;
    it.hold = hold;
    send_items = {send_items, it};
  endtask

  // One packet of random content. With last_carries set the final payload byte rides
  // on the end item; otherwise a separate empty end item closes the packet.
  task automatic add_packet(input int n_bytes, input bit last_carries, input bit hold);
    bit first;
    bit eop;
    first = 1'b1;
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, hold && first);
        first = 1'b0;
      end
      eop = (k == n_bytes - 1) && last_carries;
      add_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, eop, hold && first);
      first = 1'b0;
    end
    if (n_bytes == 0 || !last_carries)
      add_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b1, hold && first);
  endtask

  initial begin
    // Empty packets, including an all-ones id passed straight through.
    add_item(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b0);
    add_item(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0);
    // A single byte that arrives on the end item.
    add_item(8'hFE, 8'h80, 8'h00, 1'b1, 1'b1, 1'b0);
    // Extreme bytes with an empty item in the middle and an empty end item.
    add_item(8'h11, 8'h22, 8'hFF, 1'b1, 1'b0, 1'b0);
    add_item(8'h33, 8'h44, 8'h00, 1'b1, 1'b0, 1'b0);
    add_item(8'hFF, 8'hFF, 8'hC3, 1'b0, 1'b0, 1'b0);
    add_item(8'h00, 8'h00, 8'h5A, 1'b1, 1'b0, 1'b0);
    add_item(8'h01, 8'h7F, 8'hA5, 1'b0, 1'b1, 1'b0);
    // Two bytes, then the end item carries a third.
    add_item(8'h00, 8'h00, 8'h81, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 8'h00, 8'h7E, 1'b1, 1'b0, 1'b0);
    add_item(8'hAA, 8'h55, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_item(8'h55, 8'hAA, 8'h01, 1'b0, 1'b1, 1'b1);

    // A packet that exactly fills the buffer, then one that overflows it.
    add_packet(MAX_DATA, 1'b0, 1'b0);
    add_packet(MAX_DATA + 3, 1'b1, 1'b1);
    while (send_items.size() < 420) begin
      if ($urandom_range(0, 19) == 0)
        add_packet($urandom_range(MAX_DATA - 1, MAX_DATA + 4), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) == 0);
      else
        add_packet($urandom_range(0, 8), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 24) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (send_items.size() != 0 || in_valid) @(posedge clk);
    while (frame_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Input driver: a new item goes out only once the current one has been taken.
  always @(negedge clk) begin
    nxt_valid = in_valid;
    if (!rst && (!in_valid || in_sent)) begin
      if (in_sent) begin
        in_sent = 1'b0;
        send_gap = draw_wait(send_calm);
      end
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (send_items.size() != 0 &&
                   !(send_items[0].hold && frame_expect.size() != 0)) begin
        nxt = send_items.pop_front();
        target_addr <= nxt.id;
        command <= nxt.cmd;
        payload_byte <= nxt.pb;
        has_payload <= nxt.has;
        end_of_packet <= nxt.eop;
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        build_frame(target_addr, command, payload_byte, has_payload, end_of_packet);
        in_sent = 1'b1;
      end
      if (out_valid && !out_stall) begin
        recv_wait = draw_wait(recv_calm);
        if (frame_expect.size() == 0) begin
          $error("frame byte %h with nothing expected", frame_byte);
          err_count++;
        end else begin
          want = frame_expect.pop_front();
          if (frame_byte !== want.fbyte) begin
            $error("frame_byte: expected %h, got %h", want.fbyte, frame_byte);
            err_count++;
          end
          if (frame_last !== want.flast) begin
            $error("frame_last: expected %b, got %b", want.flast, frame_last);
            err_count++;
          end
          if (overflow !== want.fovf) begin
            $error("overflow: expected %b, got %b", want.fovf, overflow);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
